[rtl/banned_word_mask_filter_defines.svh]
// Assertion macros for the files of the banned word filter.
// Every property is sampled on the rising clock edge and is off during reset.
`ifndef BANNED_WORD_MASK_FILTER_DEFINES_SVH
`define BANNED_WORD_MASK_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BWMF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BWMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bwmf_pkg.sv]
package bwmf_pkg;

  localparam int BAN_WORDS_DEF      = 4;
  localparam int MAX_WORD_CHARS_DEF = 8;
  localparam int COUNT_WIDTH_DEF    = 16;

  localparam int CHAR_W     = 8;
  localparam int MAX_CHARS  = 8;
  localparam int WORD_W     = CHAR_W * MAX_CHARS;
  localparam int LEN_W      = 4;
  localparam int SLOTS      = 4;
  localparam int CNT_OUT_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int BCOUNT_W   = 3;
  localparam int BLENS_W    = LEN_W * SLOTS;

  localparam logic [CHAR_W-1:0] MASK_CHAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

  localparam logic [CFG_IDX_W-1:0] REG_BAN_WORD_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAN_WORD_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAN_LENGTHS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BAN_COUNT   = 3'd5;

  // What one lane found for its banned word.
  typedef struct packed {
    logic                 hit;
    logic [MAX_CHARS-1:0] mask;
  } lane_res_t;

  // One finished result item.
  typedef struct packed {
    logic [WORD_W-1:0]               masked_chars;
    logic [LEN_W-1:0]                masked_len;
    logic [SLOTS-1:0]                hit_flags;
    logic [SLOTS-1:0][CNT_OUT_W-1:0] counts;
  } result_t;

  function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

[rtl/bwmf_lane.sv]
// Finds the leftmost occurrence of one banned word in the folded word and
// marks the bytes it covers.
module bwmf_lane #(
  parameter int MAX_WORD_CHARS = bwmf_pkg::MAX_WORD_CHARS_DEF
) (
  input  logic [bwmf_pkg::WORD_W-1:0] folded,
  input  logic [bwmf_pkg::LEN_W-1:0]  word_len,
  input  logic [bwmf_pkg::WORD_W-1:0] ban_word,
  input  logic [bwmf_pkg::LEN_W-1:0]  ban_len,
  input  logic                        enable,
  output bwmf_pkg::lane_res_t         res
);

  localparam int CW = bwmf_pkg::CHAR_W;

  always_comb begin
    logic [MAX_WORD_CHARS-1:0]      cand;
    logic [MAX_WORD_CHARS-1:0]      first;
    logic                           found;
    logic [bwmf_pkg::MAX_CHARS-1:0] mask;
    cand  = '0;
    first = '0;
    found = 1'b0;
    mask  = '0;
    // A start position is a candidate when the banned word fits before the
    // end of the word and every byte of it agrees.
    for (int p = 0; p < MAX_WORD_CHARS; p++) begin
      cand[p] = (({1'b0, ban_len} + 5'(p)) <= {1'b0, word_len});
      for (int i = 0; i < MAX_WORD_CHARS; i++) begin
        if (p + i < MAX_WORD_CHARS) begin
          if ((4'(i) < ban_len) &&
              (folded[CW*(p+i) +: CW] != ban_word[CW*i +: CW])) begin
            cand[p] = 1'b0;
          end
        end
      end
    end
    for (int p = 0; p < MAX_WORD_CHARS; p++) begin
      first[p] = cand[p] & ~found & enable;
      found    = found | first[p];
    end
    for (int j = 0; j < MAX_WORD_CHARS; j++) begin
      for (int p = 0; p <= j; p++) begin
        if (first[p] && (4'(j - p) < ban_len)) begin
          mask[j] = 1'b1;
        end
      end
    end
    res.hit  = found;
    res.mask = mask;
  end

endmodule

[rtl/bwmf_merge.sv]
// Combines the lane results: ORs the masks into the original-case word and
// gathers the hit flags.
module bwmf_merge #(
  parameter int BAN_WORDS      = bwmf_pkg::BAN_WORDS_DEF,
  parameter int MAX_WORD_CHARS = bwmf_pkg::MAX_WORD_CHARS_DEF
) (
  input  bwmf_pkg::lane_res_t          lanes [BAN_WORDS],
  input  logic [bwmf_pkg::WORD_W-1:0]  word_chars,
  input  logic [bwmf_pkg::LEN_W-1:0]   word_len,
  output logic [bwmf_pkg::WORD_W-1:0]  masked_chars,
  output logic [bwmf_pkg::SLOTS-1:0]   hit_flags
);

  localparam int CW = bwmf_pkg::CHAR_W;

  always_comb begin
    logic [bwmf_pkg::MAX_CHARS-1:0] mask_any;
    mask_any     = '0;
    hit_flags    = '0;
    masked_chars = '0;
    for (int k = 0; k < BAN_WORDS; k++) begin
      mask_any     = mask_any | lanes[k].mask;
      hit_flags[k] = lanes[k].hit;
    end
    // Bytes at or past the length stay zero.
    for (int i = 0; i < MAX_WORD_CHARS; i++) begin
      if (4'(i) < word_len) begin
        masked_chars[CW*i +: CW] = mask_any[i] ? bwmf_pkg::MASK_CHAR
                                               : word_chars[CW*i +: CW];
      end
    end
  end

endmodule

[rtl/banned_word_mask_filter.sv]
// Results are registered in the output register, or in the skid entry while out is held.
// Throughput: one item per cycle while in_stall is low; all lanes compare every position
// in parallel and the counters take a single saturating increment in the same cycle.
// While out is stalled, a skid entry behind the output register takes one more item.
// The input then stalls until the output drains.
// Reset (rst_n low, synchronous) clears the configuration registers, counters and valids.
module banned_word_mask_filter #(
  parameter int BAN_WORDS      = bwmf_pkg::BAN_WORDS_DEF,
  parameter int MAX_WORD_CHARS = bwmf_pkg::MAX_WORD_CHARS_DEF,
  parameter int COUNT_WIDTH    = bwmf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bwmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bwmf_pkg::WORD_W-1:0]       cfg_data,
  // Input items.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bwmf_pkg::WORD_W-1:0]       in_word_chars,
  input  logic [bwmf_pkg::LEN_W-1:0]        in_word_len,
  input  logic                              in_start_of_text,
  // Result items.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bwmf_pkg::WORD_W-1:0]       out_masked_chars,
  output logic [bwmf_pkg::LEN_W-1:0]        out_masked_len,
  output logic [bwmf_pkg::SLOTS-1:0]        out_hit_flags,
  output logic [bwmf_pkg::CNT_OUT_W-1:0]    out_count_0,
  output logic [bwmf_pkg::CNT_OUT_W-1:0]    out_count_1,
  output logic [bwmf_pkg::CNT_OUT_W-1:0]    out_count_2,
  output logic [bwmf_pkg::CNT_OUT_W-1:0]    out_count_3
);

`include "banned_word_mask_filter_defines.svh"

  localparam int CW  = bwmf_pkg::CHAR_W;
  localparam int LW  = bwmf_pkg::LEN_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // Configuration registers. Only the banned words that lanes exist for are
  // stored; writes to the others have no visible effect.
  logic [bwmf_pkg::WORD_W-1:0]   ban_word_r [BAN_WORDS];
  logic [bwmf_pkg::BLENS_W-1:0]  ban_lengths_r;
  logic [bwmf_pkg::BCOUNT_W-1:0] ban_count_r;

  logic [COUNT_WIDTH-1:0] cnt_r   [BAN_WORDS];
  logic [COUNT_WIDTH-1:0] cnt_nxt [BAN_WORDS];

  logic                 out_valid_r, skid_valid_r;
  bwmf_pkg::result_t    out_r, skid_r, res_nxt;

  logic                         in_accept;
  logic [LW-1:0]                word_len_eff;
  logic [bwmf_pkg::WORD_W-1:0]  folded;
  logic [bwmf_pkg::BCOUNT_W-1:0] used;
  bwmf_pkg::lane_res_t          lane_res [BAN_WORDS];
  logic [bwmf_pkg::WORD_W-1:0]  masked_chars;
  logic [bwmf_pkg::SLOTS-1:0]   hit_flags;

  assign cfg_ready = 1'b1;
  // The input stalls only while the skid entry is occupied.
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < BAN_WORDS; k++) begin
        ban_word_r[k] <= '0;
      end
      ban_lengths_r <= '0;
      ban_count_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index) inside
        [bwmf_pkg::REG_BAN_WORD_0:bwmf_pkg::REG_BAN_WORD_3]: begin
          for (int k = 0; k < BAN_WORDS; k++) begin
            if (cfg_index == bwmf_pkg::CFG_IDX_W'(k)) begin
              ban_word_r[k] <= cfg_data;
            end
          end
        end
        bwmf_pkg::REG_BAN_LENGTHS: begin
          ban_lengths_r <= cfg_data[bwmf_pkg::BLENS_W-1:0];
        end
        bwmf_pkg::REG_BAN_COUNT: begin
          ban_count_r <= cfg_data[bwmf_pkg::BCOUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Effective word length and number of enabled banned words, both clamped.
  assign word_len_eff = (in_word_len > LW'(MAX_WORD_CHARS)) ? LW'(MAX_WORD_CHARS)
                                                            : in_word_len;
  assign used = (ban_count_r > bwmf_pkg::BCOUNT_W'(BAN_WORDS))
              ? bwmf_pkg::BCOUNT_W'(BAN_WORDS) : ban_count_r;

  // Matching runs on a lower-case copy; masking works on the original bytes.
  always_comb begin
    for (int i = 0; i < bwmf_pkg::MAX_CHARS; i++) begin
      folded[CW*i +: CW] = bwmf_pkg::fold_byte(in_word_chars[CW*i +: CW]);
    end
  end

  // One lane for each banned word.
  for (genvar k = 0; k < BAN_WORDS; k++) begin : g_lane
    bwmf_lane #(
      .MAX_WORD_CHARS(MAX_WORD_CHARS)
    ) u_lane (
      .folded   (folded),
      .word_len (word_len_eff),
      .ban_word (ban_word_r[k]),
      .ban_len  (ban_lengths_r[LW*k +: LW]),
      .enable   (bwmf_pkg::BCOUNT_W'(k) < used),
      .res      (lane_res[k])
    );
  end

  bwmf_merge #(
    .BAN_WORDS      (BAN_WORDS),
    .MAX_WORD_CHARS (MAX_WORD_CHARS)
  ) u_merge (
    .lanes        (lane_res),
    .word_chars   (in_word_chars),
    .word_len     (word_len_eff),
    .masked_chars (masked_chars),
    .hit_flags    (hit_flags)
  );

  // Counter update: start of text clears first, then a hit adds one unless
  // the counter has already saturated. The result reports the new values.
  always_comb begin
    logic [COUNT_WIDTH-1:0] base;
    base = '0;
    res_nxt.masked_chars = masked_chars;
    res_nxt.masked_len   = word_len_eff;
    res_nxt.hit_flags    = hit_flags;
    res_nxt.counts       = '0;
    for (int k = 0; k < BAN_WORDS; k++) begin
      base = in_start_of_text ? '0 : cnt_r[k];
      if (hit_flags[k] && (base != CNT_MAX)) begin
        cnt_nxt[k] = base + COUNT_WIDTH'(1);
      end else begin
        cnt_nxt[k] = base;
      end
      res_nxt.counts[k] = bwmf_pkg::CNT_OUT_W'(cnt_nxt[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < BAN_WORDS; k++) begin
        cnt_r[k] <= '0;
      end
    end else if (in_accept) begin
      for (int k = 0; k < BAN_WORDS; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  // Output register with a skid entry behind it. When the output register
  // drains, the skid entry moves up first; otherwise a new item goes straight
  // to the output. A new item arriving while the output is held goes to skid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_accept) begin
        out_r <= res_nxt;
      end
    end else if (in_accept) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_masked_chars = out_r.masked_chars;
  assign out_masked_len   = out_r.masked_len;
  assign out_hit_flags    = out_r.hit_flags;
  assign out_count_0      = out_r.counts[0];
  assign out_count_1      = out_r.counts[1];
  assign out_count_2      = out_r.counts[2];
  assign out_count_3      = out_r.counts[3];

  // The skid entry is only ever filled behind a held output item.
  `BWMF_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r,
                    "skid entry occupied while output register is empty")
  // An item taken while the output is held must land in the skid entry.
  `BWMF_ASSERT_NEXT(a_held_goes_to_skid, clk, rst_n,
                    in_accept && out_valid_r && out_stall, skid_valid_r,
                    "item accepted behind a held output was lost")
  // The reported length never exceeds the clamp.
  `BWMF_ASSERT_SAME(a_len_clamped, clk, rst_n, out_valid_r,
                    out_masked_len <= LW'(MAX_WORD_CHARS),
                    "output length above the word size")
  // Lanes that do not exist never report a hit.
  `BWMF_ASSERT_SAME(a_no_phantom_hits, clk, rst_n, out_valid_r,
                    (out_hit_flags >> BAN_WORDS) == '0,
                    "hit flag set for a banned word without a lane")

endmodule

[sim/banned_word_mask_filter_tb.sv]
class ban_scoreboard;

  logic [bwmf_pkg::WORD_W-1:0]    ban_word [bwmf_pkg::SLOTS];
  logic [bwmf_pkg::BLENS_W-1:0]   ban_lens;
  logic [bwmf_pkg::BCOUNT_W-1:0]  ban_cnt;
  logic [bwmf_pkg::CNT_OUT_W-1:0] hit_cnt [bwmf_pkg::SLOTS];
  bwmf_pkg::result_t              expected_q [$];
  int errors;
  int checked;
  int accepted;

  function new();
    for (int k = 0; k < bwmf_pkg::SLOTS; k++) begin
      ban_word[k] = '0;
      hit_cnt[k]  = '0;
    end
    ban_lens = '0;
    ban_cnt  = '0;
    errors   = 0;
    checked  = 0;
    accepted = 0;
  endfunction

  function void write_reg(logic [bwmf_pkg::CFG_IDX_W-1:0] idx,
                          logic [bwmf_pkg::WORD_W-1:0] data);
    if (idx <= bwmf_pkg::REG_BAN_WORD_3) begin
      ban_word[idx] = data;
    end else if (idx == bwmf_pkg::REG_BAN_LENGTHS) begin
      ban_lens = data[bwmf_pkg::BLENS_W-1:0];
    end else if (idx == bwmf_pkg::REG_BAN_COUNT) begin
      ban_cnt = data[bwmf_pkg::BCOUNT_W-1:0];
    end
  endfunction

  // Works out the masked word, hit flags and counters for one accepted word.
  function void note_input(logic [bwmf_pkg::WORD_W-1:0] chars,
                           logic [bwmf_pkg::LEN_W-1:0] len, logic sot);
    bwmf_pkg::result_t r;
    logic [bwmf_pkg::CHAR_W-1:0] folded [bwmf_pkg::MAX_CHARS];
    logic [bwmf_pkg::CHAR_W-1:0] c;
    logic [bwmf_pkg::MAX_CHARS-1:0] mask;
    int wlen;
    int used;
    int blen;
    int at;
    bit found;
    bit same;
    wlen = (len > bwmf_pkg::MAX_CHARS) ? bwmf_pkg::MAX_CHARS : int'(len);
    used = (ban_cnt > bwmf_pkg::SLOTS) ? bwmf_pkg::SLOTS : int'(ban_cnt);
    if (sot) begin
      for (int k = 0; k < bwmf_pkg::SLOTS; k++) hit_cnt[k] = '0;
    end
    for (int i = 0; i < bwmf_pkg::MAX_CHARS; i++) begin
      c = chars[8*i +: 8];
      if (c >= bwmf_pkg::UPPER_FIRST && c <= bwmf_pkg::UPPER_LAST) begin
        c = c + bwmf_pkg::CASE_OFFSET;
      end
      folded[i] = c;
    end
    r = '0;
    mask = '0;
    for (int k = 0; k < used; k++) begin
      blen  = int'(ban_lens[4*k +: 4]);
      found = 1'b0;
      at    = 0;
      for (int p = 0; p + blen <= wlen && !found; p++) begin
        same = 1'b1;
        for (int i = 0; i < blen; i++) begin
          if (folded[p+i] != ban_word[k][8*i +: 8]) same = 1'b0;
        end
        if (same) begin
          found = 1'b1;
          at    = p;
        end
      end
      if (found) begin
        r.hit_flags[k] = 1'b1;
        if (hit_cnt[k] != '1) hit_cnt[k] = hit_cnt[k] + 1'b1;
        for (int i = 0; i < blen; i++) mask[at+i] = 1'b1;
      end
    end
    for (int i = 0; i < wlen; i++) begin
      r.masked_chars[8*i +: 8] = mask[i] ? bwmf_pkg::MASK_CHAR : chars[8*i +: 8];
    end
    r.masked_len = wlen[bwmf_pkg::LEN_W-1:0];
    for (int k = 0; k < bwmf_pkg::SLOTS; k++) r.counts[k] = hit_cnt[k];
    expected_q.insert(expected_q.size(), r);
    accepted++;
  endfunction

  task report(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch in %s at result %0d: got %h, expected %h",
             field, checked, got, want);
  endtask

  task check_result(logic [bwmf_pkg::WORD_W-1:0] chars, logic [bwmf_pkg::LEN_W-1:0] len,
                    logic [bwmf_pkg::SLOTS-1:0] hits,
                    logic [bwmf_pkg::SLOTS-1:0][bwmf_pkg::CNT_OUT_W-1:0] counts);
    bwmf_pkg::result_t want;
    if (expected_q.size() == 0) begin
      report("unexpected result item", chars, '0);
    end else begin
      want = expected_q.pop_front();
      if (chars !== want.masked_chars) report("masked_chars", chars, want.masked_chars);
      if (len !== want.masked_len) report("masked_len", 64'(len), 64'(want.masked_len));
      if (hits !== want.hit_flags) report("hit_flags", 64'(hits), 64'(want.hit_flags));
      for (int k = 0; k < bwmf_pkg::SLOTS; k++) begin
        if (counts[k] !== want.counts[k]) begin
          report($sformatf("count_%0d", k), 64'(counts[k]), 64'(want.counts[k]));
        end
      end
      checked++;
    end
  endtask

  function int pending();
    return expected_q.size();
  endfunction

endclass

module banned_word_mask_filter_tb;

  localparam int CFG_IDX_W = bwmf_pkg::CFG_IDX_W;
  localparam int WORD_W    = bwmf_pkg::WORD_W;
  localparam int LEN_W     = bwmf_pkg::LEN_W;
  localparam int SLOTS     = bwmf_pkg::SLOTS;
  localparam int CNT_OUT_W = bwmf_pkg::CNT_OUT_W;
  localparam int BCOUNT_W  = bwmf_pkg::BCOUNT_W;
  localparam int BLENS_W   = bwmf_pkg::BLENS_W;
  localparam int MAX_CHARS = bwmf_pkg::MAX_CHARS;
  localparam int CHAR_W    = bwmf_pkg::CHAR_W;

  // The run is bounded by this many clock cycles. The slowest legal run of the
  // stimulus below is well under a third of it.
  localparam int LIMIT       = 800000;
  // Length of the unbroken stream in which every banned word hits every word.
  localparam int RUN_ITEMS   = 40;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 125;

  // Register indexes above the last real register; writes there must do nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 cfg_valid        = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [WORD_W-1:0]    cfg_data         = '0;
  logic                 in_valid         = 1'b0;
  logic                 in_stall;
  logic [WORD_W-1:0]    in_word_chars    = '0;
  logic [LEN_W-1:0]     in_word_len      = '0;
  logic                 in_start_of_text = 1'b0;
  logic                 out_valid;
  logic                 out_stall        = 1'b0;
  logic [WORD_W-1:0]    out_masked_chars;
  logic [LEN_W-1:0]     out_masked_len;
  logic [SLOTS-1:0]     out_hit_flags;
  logic [CNT_OUT_W-1:0] out_count_0;
  logic [CNT_OUT_W-1:0] out_count_1;
  logic [CNT_OUT_W-1:0] out_count_2;
  logic [CNT_OUT_W-1:0] out_count_3;

  ban_scoreboard sb = new();

  // When steady is set, neither side inserts idle cycles, so the block sees
  // long unbroken streams at full rate.
  bit steady = 1'b0;
  int cycles = 0;
  int settings = 0;

  // The banned words last programmed, kept on the stimulus side so that random
  // words can be built around them.
  logic [WORD_W-1:0] plan_word [SLOTS];
  logic [LEN_W-1:0]  plan_len  [SLOTS];
  logic [BCOUNT_W-1:0] plan_count;

  always #2 clk = ~clk;

  banned_word_mask_filter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_word_chars    (in_word_chars),
    .in_word_len      (in_word_len),
    .in_start_of_text (in_start_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_masked_chars (out_masked_chars),
    .out_masked_len   (out_masked_len),
    .out_hit_flags    (out_hit_flags),
    .out_count_0      (out_count_0),
    .out_count_1      (out_count_1),
    .out_count_2      (out_count_2),
    .out_count_3      (out_count_3)
  );

  // Every handshake is observed here, at the clock edge, on the values that
  // were settled before the edge. Register writes and input items feed the
  // scoreboard's model; result items are checked against its oldest entry.
  // The input is noted before the output is checked, so the ordering is right
  // whatever the latency of the block is.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, sb.pending());
      $display("status: fail");
      $finish;
    end else if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_input(in_word_chars, in_word_len, in_start_of_text);
      if (out_valid && !out_stall) begin
        sb.check_result(out_masked_chars, out_masked_len, out_hit_flags,
                        {out_count_3, out_count_2, out_count_1, out_count_0});
      end
    end
  end

  // Idle lengths: mostly none or a few cycles, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // The result side stalls in bursts of random length, separated by short
  // stretches in which it takes every item.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = steady ? 0 : gap_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  function automatic logic [WORD_W-1:0] pack_str(string s);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int i = 0; i < s.len() && i < MAX_CHARS; i++) w[8*i +: 8] = s[i];
    return w;
  endfunction

  // A lower-case letter is sometimes turned to upper case; the block should
  // fold it back before comparing.
  function automatic logic [CHAR_W-1:0] vary_case(logic [CHAR_W-1:0] c);
    if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) begin
      return c - bwmf_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  // Bytes of random words lean on a tiny alphabet so that partial matches,
  // repeats and overlaps show up often.
  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return vary_case(CHAR_W'(8'h61 + $urandom_range(0, 2)));
    if (r < 75) return vary_case(CHAR_W'(8'h61 + $urandom_range(0, 25)));
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // A random banned word. Bytes past its length are left as garbage, which the
  // block must ignore.
  task automatic make_ban(output logic [WORD_W-1:0] w, output logic [LEN_W-1:0] l);
    int r;
    int q;
    r = $urandom_range(0, 99);
    if (r < 10) l = '0;
    else if (r < 80) l = LEN_W'($urandom_range(1, 4));
    else if (r < 90) l = LEN_W'($urandom_range(5, 8));
    else l = LEN_W'($urandom_range(9, 15));
    w = {$urandom(), $urandom()};
    for (int i = 0; i < l && i < MAX_CHARS; i++) begin
      q = $urandom_range(0, 99);
      if (q < 70) w[8*i +: 8] = CHAR_W'(8'h61 + $urandom_range(0, 2));
      else if (q < 85) w[8*i +: 8] = CHAR_W'(8'h61 + $urandom_range(0, 25));
      else if (q < 90) w[8*i +: 8] = CHAR_W'(8'h41 + $urandom_range(0, 25));
    end
  endtask

  // A random word. Most of the time one or two of the enabled banned words are
  // planted in it at a random place and with random case.
  task automatic make_item(output logic [WORD_W-1:0] chars, output logic [LEN_W-1:0] len);
    int r;
    int eff;
    int used;
    int k;
    int bl;
    int p;
    r = $urandom_range(0, 99);
    if (r < 5) len = LEN_W'($urandom_range(9, 15));
    else if (r < 10) len = '0;
    else len = LEN_W'($urandom_range(1, 8));
    for (int i = 0; i < MAX_CHARS; i++) chars[8*i +: 8] = pick_char();
    eff  = (len > MAX_CHARS) ? MAX_CHARS : int'(len);
    used = (plan_count > SLOTS) ? SLOTS : int'(plan_count);
    for (int n = 0; n < 2; n++) begin
      if (used > 0 && $urandom_range(0, 99) < (n == 0 ? 70 : 25)) begin
        k  = $urandom_range(0, used - 1);
        bl = int'(plan_len[k]);
        if (bl >= 1 && bl <= eff) begin
          p = $urandom_range(0, eff - bl);
          for (int i = 0; i < bl; i++) chars[8*(p+i) +: 8] = vary_case(plan_word[k][8*i +: 8]);
        end
      end
    end
  endtask

  // Offers one item and holds it until the block takes it, then idles the
  // input for a random number of cycles.
  task automatic send_item(input logic [WORD_W-1:0] chars, input logic [LEN_W-1:0] len,
                           input logic sot);
    int gap;
    in_valid         <= 1'b1;
    in_word_chars    <= chars;
    in_word_len      <= len;
    in_start_of_text <= sot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Stops the input and waits until every expected result item has come out.
  // It first waits on the clock so that the last accepted item has been noted.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes all registers from the plan arrays. Unused upper bits of the length
  // and count writes carry garbage, and a write to a spare index is mixed in.
  task automatic program_bans();
    logic [WORD_W-1:0] data;
    for (int k = 0; k < SLOTS; k++) begin
      cfg_write(CFG_IDX_W'(bwmf_pkg::REG_BAN_WORD_0 + k), plan_word[k]);
    end
    data = {$urandom(), $urandom()};
    data[BLENS_W-1:0] = {plan_len[3], plan_len[2], plan_len[1], plan_len[0]};
    cfg_write(bwmf_pkg::REG_BAN_LENGTHS, data);
    cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom(), $urandom()});
    data = {$urandom(), $urandom()};
    data[BCOUNT_W-1:0] = plan_count;
    cfg_write(bwmf_pkg::REG_BAN_COUNT, data);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin
    logic [WORD_W-1:0] w;
    logic [LEN_W-1:0]  l;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the reset register values no banned word is enabled.
    send_item(pack_str("Hello"), 4'd5, 1'b1);
    send_item('0, 4'd0, 1'b0);
    drain();

    // A short word, a pair that can overlap it, an empty word with garbage in
    // its register, and an upper-case word that folding can never match.
    plan_word[0] = pack_str("bad");
    plan_word[1] = pack_str("ab");
    plan_word[2] = '1;
    plan_word[3] = pack_str("Zq");
    plan_len[0] = 4'd3;
    plan_len[1] = 4'd2;
    plan_len[2] = 4'd0;
    plan_len[3] = 4'd2;
    plan_count  = 3'd4;
    program_bans();
    send_item(pack_str("xbadbad"), 4'd7, 1'b1);
    send_item(pack_str("BADab"), 4'd5, 1'b0);
    send_item(pack_str("aab"), 4'd3, 1'b0);
    send_item(pack_str("zq"), 4'd2, 1'b0);
    send_item(pack_str("ZQ"), 4'd2, 1'b0);
    send_item('1, 4'd8, 1'b0);
    send_item('0, 4'd0, 1'b0);
    // A length above eight is clipped to eight.
    send_item(pack_str("badbadxx"), 4'd15, 1'b0);
    // Bytes past the word length must be ignored and come out as zero.
    send_item(pack_str("bad") | 64'hFFFF_FFFF_FF00_0000, 4'd3, 1'b0);
    send_item(pack_str("qq"), 4'd2, 1'b1);
    // The bytes on both sides of the upper-case and lower-case ranges.
    send_item(64'h7B7A_6160_5B5A_4140, 4'd8, 1'b0);
    drain();

    // A full-length banned word, one too long to ever match, a single letter,
    // and a ban count above the number of slots.
    plan_word[0] = pack_str("abcdefgh");
    plan_word[1] = pack_str("ab");
    plan_word[2] = pack_str("a") | 64'hA5A5_A5A5_A5A5_A500;
    plan_word[3] = '0;
    plan_len[0] = 4'd8;
    plan_len[1] = 4'd9;
    plan_len[2] = 4'd1;
    plan_len[3] = 4'd15;
    plan_count  = 3'd7;
    program_bans();
    send_item(pack_str("ABCDEFGH"), 4'd8, 1'b0);
    send_item(pack_str("abcdefg"), 4'd7, 1'b0);
    send_item(pack_str("ab"), 4'd2, 1'b0);
    send_item(pack_str("Abcdefgh"), 4'd12, 1'b0);
    drain();

    // Empty banned words in every slot hit every word, so all four counters
    // climb together over an unbroken stream at full rate.
    for (int k = 0; k < SLOTS; k++) begin
      plan_word[k] = {$urandom(), $urandom()};
      plan_len[k]  = 4'd0;
    end
    plan_count = 3'd4;
    program_bans();
    steady = 1'b1;
    for (int n = 0; n < RUN_ITEMS; n++) begin
      send_item({$urandom(), $urandom()}, LEN_W'($urandom_range(0, 15)), n == 0);
    end
    drain();
    steady = 1'b0;

    // With only the first word enabled, the other counters keep their values
    // and are still reported.
    plan_word[0] = pack_str("a");
    plan_len[0]  = 4'd1;
    plan_count   = 3'd1;
    program_bans();
    send_item(pack_str("a"), 4'd1, 1'b0);
    send_item(pack_str("b"), 4'd1, 1'b0);
    drain();

    // Random phases. The first few use extreme register settings; the rest use
    // random banned words. Every fourth phase runs without idle cycles.
    for (int p = 0; p < PHASES; p++) begin
      for (int k = 0; k < SLOTS; k++) begin
        case (p)
          0: begin
            plan_word[k] = '0;
            plan_len[k]  = 4'd0;
          end
          1: begin
            plan_word[k] = '1;
            plan_len[k]  = 4'd15;
          end
          2: begin
            for (int i = 0; i < MAX_CHARS; i++) begin
              plan_word[k][8*i +: 8] = CHAR_W'(8'h61 + $urandom_range(0, 2));
            end
            plan_len[k] = 4'd8;
          end
          default: begin
            make_ban(w, l);
            plan_word[k] = w;
            plan_len[k]  = l;
          end
        endcase
      end
      if (p == 0 || p == 2) plan_count = 3'd4;
      else if (p == 1) plan_count = 3'd7;
      else if (p == 3) plan_count = 3'd0;
      else if ($urandom_range(0, 99) < 70) plan_count = 3'd4;
      else plan_count = BCOUNT_W'($urandom_range(0, 7));
      program_bans();
      steady = (p % 4 == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        make_item(w, l);
        send_item(w, l, $urandom_range(0, 99) < 3);
      end
      drain();
      steady = 1'b0;
    end

    // Let a few more cycles pass so that a stray extra result would be seen.
    repeat (10) @(posedge clk);

    $display("covered %0d words under %0d register settings, %0d results checked, %0d mismatches",
             sb.accepted, settings, sb.checked, sb.errors);
    $display("run included a %0d-word full-rate stretch in which every banned word hit",
             RUN_ITEMS);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
